// ----- sv/xtea_pkg.sv -----
// ----------------------------------------------------------------------------
// xtea_pkg
// shared types, constants and the round mixing function of the xtea core
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam logic [31:0] ROUND_STEP = 32'h9E37_79B9;
    localparam int KEY_WORDS = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic        command;
        logic [31:0] word_first;
        logic [31:0] word_second;
    } in_word_t;

    typedef struct packed
    {
        logic [31:0] result_first;
        logic [31:0] result_second;
    } out_word_t;

    // data handed from one cell to the next
    typedef struct packed
    {
        logic        cmd;
        logic [31:0] v0;
        logic [31:0] v1;
    } xtea_stage_t;

    typedef logic [KEY_WORDS-1:0][31:0] key_t;

    function automatic logic [31:0] xtea_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// ----- sv/xtea_cell.sv -----
// ----------------------------------------------------------------------------
// xtea_cell
// one feistel half-round; updates one half of the block and passes it on
// ----------------------------------------------------------------------------
module xtea_cell #(
    parameter int          PHASE   = 0,
    parameter logic [31:0] ENC_SUM = 32'h0,
    parameter logic [31:0] DEC_SUM = 32'h0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  xtea_pkg::xtea_stage_t stage_in,
    input  xtea_pkg::key_t       key,
    output logic                 valid_out,
    output xtea_pkg::xtea_stage_t stage_out
);
    import xtea_pkg::*;

    // encrypt: phase 0 updates v0, phase 1 updates v1; decrypt the reverse
    localparam logic [1:0] ENC_IDX = (PHASE == 0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [1:0] DEC_IDX = (PHASE == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

    logic          valid_reg;
    xtea_stage_t   stage_reg;
    xtea_stage_t   stage_next;
    logic          is_enc;
    logic          upd_v0;
    logic [31:0]   src;
    logic [31:0]   dst;
    logic [31:0]   sum;
    logic [31:0]   kw;
    logic [31:0]   delta;
    logic [31:0]   dst_new;

    always_comb
    begin
        is_enc  = (stage_in.cmd == CMD_ENCRYPT);
        upd_v0  = is_enc ? (PHASE == 0) : (PHASE != 0);
        src     = upd_v0 ? stage_in.v1 : stage_in.v0;
        dst     = upd_v0 ? stage_in.v0 : stage_in.v1;
        sum     = is_enc ? ENC_SUM : DEC_SUM;
        kw      = is_enc ? key[ENC_IDX] : key[DEC_IDX];
        delta   = xtea_mix(src) ^ (sum + kw);
        dst_new = is_enc ? (dst + delta) : (dst - delta);
        stage_next = stage_in;
        if (upd_v0)
        begin
            stage_next.v0 = dst_new;
        end
        else
        begin
            stage_next.v1 = dst_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

    // the half that is not updated passes through untouched
    a_hold_other: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && (stage_out.cmd == CMD_ENCRYPT) == (PHASE == 0))
            |-> stage_out.v1 == $past(stage_in.v1))
        else $error("xtea_cell: v1 changed in a v0 half-round");

    a_hold_v0: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && (stage_out.cmd == CMD_ENCRYPT) != (PHASE == 0))
            |-> stage_out.v0 == $past(stage_in.v0))
        else $error("xtea_cell: v0 changed in a v1 half-round");

    a_cmd_kept: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> (stage_out.cmd == $past(stage_in.cmd)) && $past(valid_in))
        else $error("xtea_cell: command or valid not carried");

endmodule

// ----- sv/xtea_block_cipher.sv -----
// ----------------------------------------------------------------------------
// xtea_block_cipher
// pipelined xtea encrypt / decrypt, 64-bit block, 128-bit key
// ----------------------------------------------------------------------------
// usage
//   - load the key through cfg_we / cfg_index / cfg_data, one 32-bit key word
//     per write, only while no word is in flight
//   - present a block on in_data with start high; busy is always low, so a
//     word is taken at every edge where start is high
//   - in_data.command selects encrypt (0) or decrypt (1) per word
//   - the result appears on out_data with result_valid high for one cycle,
//     once the word has passed through every half-round cell of the row
//   - throughput is one word per cycle: the pipeline is a row of 2*ROUNDS
//     half-round cells, each registered, so the latency is set by that row
//   - the receiver cannot stall; results are strobed out and must be taken
//   - reset clears the key to zero and empties the pipeline; no result is
//     shown until a new word has gone the full length of the row
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  xtea_pkg::in_word_t           in_data,
    output logic                         result_valid,
    output xtea_pkg::out_word_t          out_data,
    input  logic                         cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import xtea_pkg::*;

    // two cells per round, one for each half of the block
    localparam int CELLS = 2 * ROUNDS;

    key_t        key_reg;
    logic        valid_chain [0:CELLS];
    xtea_stage_t stage_chain [0:CELLS];

    // key words, written one at a time; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // every cycle is open for a new word
    assign busy = 1'b0;

    // head of the row
    assign valid_chain[0]     = start && !busy;
    assign stage_chain[0].cmd = in_data.command;
    assign stage_chain[0].v0  = in_data.word_first;
    assign stage_chain[0].v1  = in_data.word_second;

    // each cell carries its own running-sum constants for both directions
    for (genvar h = 0; h < CELLS; h++)
    begin : g_cell
        localparam int N  = h / 2;
        localparam int PH = h % 2;
        localparam logic [31:0] ENC_S = 32'(ROUND_STEP * 32'(N + PH));
        localparam logic [31:0] DEC_S = 32'(ROUND_STEP * 32'(ROUNDS - N - PH));

        xtea_cell #(
            .PHASE   (PH),
            .ENC_SUM (ENC_S),
            .DEC_SUM (DEC_S)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[h]),
            .stage_in  (stage_chain[h]),
            .key       (key_reg),
            .valid_out (valid_chain[h+1]),
            .stage_out (stage_chain[h+1])
        );
    end

    // the last cell's registers are the output register
    assign result_valid           = valid_chain[CELLS];
    assign out_data.result_first  = stage_chain[CELLS].v0;
    assign out_data.result_second = stage_chain[CELLS].v1;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, CELLS))
        else $error("xtea_block_cipher: result without a word taken");

    a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> stage_chain[CELLS].cmd == $past(in_data.command, CELLS))
        else $error("xtea_block_cipher: result paired with wrong command");

    a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(valid_chain[1], CELLS - 1))
        else $error("xtea_block_cipher: pipeline valid lost or invented");

endmodule

// ----- verif/tb_xtea_block_cipher.sv -----
// ----------------------------------------------------------------------------
// tb_xtea_block_cipher
// self-checking bench for the pipelined xtea encrypt / decrypt core
// ----------------------------------------------------------------------------
// a short table of edge-case blocks runs first, under the reset key and under
// an all-ones key. Random phases follow, each loading a fresh key while the
// pipeline is empty. Some blocks are decrypted or encrypted again right
// after, so round trips are covered. Every accepted word is run through a
// local xtea model and queued. Each strobed result is checked against the
// oldest queued block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xtea_block_cipher;

    import xtea_pkg::*;

    localparam int NUM_ROUNDS  = 32;
    localparam int PIPE_DEPTH  = 2 * NUM_ROUNDS;
    localparam int ITEMS_TOTAL = 1950;
    localparam int PHASE_ITEMS = 240;
    localparam int TABLE_ROWS  = 10;
    localparam int CYCLE_LIMIT = 200000;

    // register indexes of the key words
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_KEY_0 = 2'd0,
        REG_KEY_1 = 2'd1,
        REG_KEY_2 = 2'd2,
        REG_KEY_3 = 2'd3
    } reg_idx_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_word_t             in_data;
    logic                 result_valid;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // local copy of the key as the core should hold it
    logic [31:0] key_model [KEY_WORDS];

    // blocks the core still owes us, oldest first
    out_word_t cipher_due [$];

    int mismatch_count;
    int cycle_count;
    int items_sent;

    // edge cases: all-zero and all-one halves, single bits, mixed halves
    in_word_t edge_table [TABLE_ROWS] = '{
        '{CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
        '{CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000},
        '{CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
        '{CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
        '{CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
        '{CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000},
        '{CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF},
        '{CMD_DECRYPT, 32'hA5A5_5A5A, 32'h5A5A_A5A5}
    };

    xtea_block_cipher #(
        .ROUNDS(NUM_ROUNDS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .in_data     (in_data),
        .result_valid(result_valid),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // xtea over the full round count with the local key copy
    function automatic out_word_t xtea_transform(input in_word_t w);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] acc;
        out_word_t   r;
        v0 = w.word_first;
        v1 = w.word_second;
        if (w.command == CMD_DECRYPT)
        begin
            // running sum starts at delta times the round count, mod 2^32
            acc = ROUND_STEP * 32'(NUM_ROUNDS);
            for (int n = 0; n < NUM_ROUNDS; n++)
            begin
                v1 -= (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (acc + key_model[acc[12:11]]);
                acc -= ROUND_STEP;
                v0 -= (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (acc + key_model[acc[1:0]]);
            end
        end
        else
        begin
            acc = '0;
            for (int n = 0; n < NUM_ROUNDS; n++)
            begin
                v0 += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (acc + key_model[acc[1:0]]);
                acc += ROUND_STEP;
                v1 += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (acc + key_model[acc[12:11]]);
            end
        end
        r.result_first  = v0;
        r.result_second = v1;
        return r;
    endfunction

    // mostly full-range values, now and then an all-zero, all-one, one-hot or one-cold word
    function automatic logic [31:0] pick_half();
        logic [31:0] onehot;
        onehot = 32'h1 << $urandom_range(31, 0);
        case ($urandom_range(15, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return onehot;
            3:       return ~onehot;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what,
                     exp_val, act_val);
        end
    endtask

    // offer one word and hold it until the core takes it
    task automatic send_block(input in_word_t w);
        start   <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        cipher_due.push_back(xtea_transform(w));
        items_sent++;
    endtask

    // sender gap; the idle buses carry junk that must be ignored
    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        repeat (cycles)
        begin
            in_data.command     <= 1'($urandom());
            in_data.word_first  <= $urandom();
            in_data.word_second <= $urandom();
            cfg_index <= CFG_IDX_W'($urandom());
            cfg_data  <= $urandom();
            @(posedge clk);
        end
    endtask

    // let every word in flight come out before touching the key
    task automatic drain_pipe();
        start <= 1'b0;
        while (cipher_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        key_model[idx] = value;
    endtask

    // junk write to one word first, then all four in a rotated order
    task automatic load_key(input key_t k);
        int rot;
        rot = $urandom_range(3, 0);
        write_reg(reg_idx_t'($urandom_range(3, 0)), $urandom());
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            write_reg(reg_idx_t'((rot + i) % KEY_WORDS), k[(rot + i) % KEY_WORDS]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_edge_table();
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            send_block(edge_table[i]);
        end
    endtask

    // result checker: the core strobes each result for one cycle
    always @(posedge clk)
    begin
        out_word_t exp_word;
        if (rst_n && result_valid === 1'b1)
        begin
            if (cipher_due.size() == 0)
            begin
                report_mismatch("unexpected word", 32'h0, out_data.result_first);
            end
            else
            begin
                exp_word = cipher_due.pop_front();
                if (out_data.result_first !== exp_word.result_first)
                begin
                    report_mismatch("result_first", exp_word.result_first,
                                    out_data.result_first);
                end
                if (out_data.result_second !== exp_word.result_second)
                begin
                    report_mismatch("result_second", exp_word.result_second,
                                    out_data.result_second);
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        key_t      next_key;
        in_word_t  w;
        out_word_t back;
        int        phase;
        int        idle_odds;
        int        n;

        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        for (int i = 0; i < KEY_WORDS; i++)
            key_model[i] = '0;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge cases under the zero key left by reset, then an all-ones key
        run_edge_table();
        drain_pipe();
        load_key({KEY_WORDS{32'hFFFF_FFFF}});
        run_edge_table();

        phase = 0;
        while (items_sent < ITEMS_TOTAL)
        begin
            drain_pipe();
            case (phase)
                0:       next_key = '0;
                1:       next_key = {KEY_WORDS{32'hFFFF_FFFF}};
                2:       next_key = {32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hAAAA_AAAA};
                default:
                begin
                    for (int i = 0; i < KEY_WORDS; i++)
                        next_key[i] = pick_half();
                end
            endcase
            load_key(next_key);

            // some phases run back to back, others with gaps of varying density
            case (phase % 3)
                0:       idle_odds = 0;
                1:       idle_odds = 4;
                default: idle_odds = 10;
            endcase

            n = 0;
            while (n < PHASE_ITEMS && items_sent < ITEMS_TOTAL)
            begin
                // no gaps in the tail of the run
                if (idle_odds != 0 && items_sent < ITEMS_TOTAL * 85 / 100 &&
                    $urandom_range(idle_odds - 1, 0) == 0)
                begin
                    idle_burst($urandom_range(14, 1));
                end
                w.command     = 1'($urandom_range(1, 0));
                w.word_first  = pick_half();
                w.word_second = pick_half();
                send_block(w);
                n++;

                // round trip: feed the block's own result back the other way
                if ($urandom_range(9, 0) < 3)
                begin
                    back = xtea_transform(w);
                    w.command     = ~w.command;
                    w.word_first  = back.result_first;
                    w.word_second = back.result_second;
                    send_block(w);
                    n++;
                end
            end
            phase++;
        end

        start <= 1'b0;
        while (cipher_due.size() != 0)
            @(posedge clk);
        // catch any stray word still in the row
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0 && cipher_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
